// File: rtl/core/dmxr_pkg.sv
// ----------------------------------------------------------------------------
// dmxr_pkg
// Types, codes and helpers shared by the DMX512 frame receiver modules.
// ----------------------------------------------------------------------------
package dmxr_pkg;

    localparam int DMXR_MAX_SLOTS = 512;
    localparam int DMXR_NUM_BANKS = 3;
    localparam int DMXR_LEN_W     = 10;
    localparam int DMXR_SLOT_W    = 10;

    localparam logic [2:0] OP_RX_BYTE = 3'd0;
    localparam logic [2:0] OP_BREAK   = 3'd1;
    localparam logic [2:0] OP_TICK    = 3'd2;
    localparam logic [2:0] OP_ACK     = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    localparam logic [1:0] NO_BANK = 2'd3;

    typedef struct packed {
        logic [2:0]             op;
        logic [7:0]             data;
        logic                   framing_error;
        logic [DMXR_SLOT_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [7:0]            read_data;
        logic [DMXR_LEN_W-1:0] slot_count;
        logic                  frame_available;
        logic [31:0]           frame_seq;
        logic [31:0]           overrun_count;
        logic [31:0]           framing_count;
    } rsp_t;

    // result fields known once the event is processed; read data follows the RAM
    typedef struct packed {
        logic                  read_hit;
        logic [1:0]            read_bank;
        logic [DMXR_LEN_W-1:0] slot_count;
        logic                  frame_available;
        logic [31:0]           frame_seq;
        logic [31:0]           overrun_count;
        logic [31:0]           framing_count;
    } stat_t;

    typedef struct packed {
        logic [DMXR_NUM_BANKS-1:0] wr_en;
        logic [DMXR_SLOT_W-1:0]    wr_addr;
        logic [7:0]                wr_data;
        logic                      rd_en;
        logic [DMXR_SLOT_W-1:0]    rd_addr;
    } mem_cmd_t;

    function automatic logic [1:0] bank_ok(input logic [1:0] b);
        bank_ok = (b == NO_BANK) ? 2'd0 : b;
    endfunction

endpackage

// File: rtl/core/dmx512_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// dmx512_frame_receiver_unit
// DMX512 receiver with three renamed frame banks and a published read-out.
// ----------------------------------------------------------------------------
// One event (rx byte, break, tick, acknowledge, slot read) is accepted per
// cycle while the result channel takes transfers, and yields one transfer on
// the result channel: the event is held in the input register, then passes the
// control logic into the result register and the registered bank RAM read.
// After reset the three banks are zeroed, during which req_ready is low;
// notify_enable writes are taken at any time.
module dmx512_frame_receiver_unit
    import dmxr_pkg::*;
#(
    parameter int MAX_SLOTS = DMXR_MAX_SLOTS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int BANK_SIZE = MAX_SLOTS + 1;
    localparam int ADDR_W    = $clog2(BANK_SIZE);

    logic     notify_reg;
    logic     a_valid_reg;
    req_t     a_item_reg;
    logic     rsp_valid_reg;
    stat_t    stat_reg;
    stat_t    stat_next;
    mem_cmd_t mem_cmd;
    logic     busy;
    logic     b_adv;
    logic     fire;
    logic [7:0] rd_data [DMXR_NUM_BANKS];
    logic [7:0] rd_sel;

    assign b_adv     = !rsp_valid_reg || rsp_ready;
    assign fire      = a_valid_reg && b_adv;
    assign req_ready = !busy && (!a_valid_reg || b_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notify_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            notify_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            a_valid_reg <= req_valid;
        end
        else if (fire)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            a_item_reg <= req;
        end
    end

    dmxr_ctrl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .item          (a_item_reg),
        .notify_enable (notify_reg),
        .busy          (busy),
        .mem_cmd       (mem_cmd),
        .stat_next     (stat_next)
    );

    for (genvar g = 0; g < DMXR_NUM_BANKS; g++)
    begin : g_bank
        dmxr_bank_ram #(
            .DEPTH (BANK_SIZE)
        ) u_ram (
            .clk     (clk),
            .wr_en   (mem_cmd.wr_en[g]),
            .wr_addr (mem_cmd.wr_addr[ADDR_W-1:0]),
            .wr_data (mem_cmd.wr_data),
            .rd_en   (mem_cmd.rd_en),
            .rd_addr (mem_cmd.rd_addr[ADDR_W-1:0]),
            .rd_data (rd_data[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (b_adv)
        begin
            rsp_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            stat_reg <= stat_next;
        end
    end

    // RAM read data holds with the result register while a transfer stalls
    always_comb
    begin
        case (stat_reg.read_bank)
            2'd0:    rd_sel = rd_data[0];
            2'd1:    rd_sel = rd_data[1];
            default: rd_sel = rd_data[2];
        endcase
    end

    assign rsp_valid            = rsp_valid_reg;
    assign rsp.read_data        = stat_reg.read_hit ? rd_sel : 8'h00;
    assign rsp.slot_count       = stat_reg.slot_count;
    assign rsp.frame_available  = stat_reg.frame_available;
    assign rsp.frame_seq        = stat_reg.frame_seq;
    assign rsp.overrun_count    = stat_reg.overrun_count;
    assign rsp.framing_count    = stat_reg.framing_count;

endmodule

// File: rtl/core/dmxr_bank_ram.sv
// ----------------------------------------------------------------------------
// dmxr_bank_ram
// One frame bank: single write port, single registered read port.
// ----------------------------------------------------------------------------
module dmxr_bank_ram #(
    parameter int DEPTH = 513
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/dmxr_ctrl.sv
// ----------------------------------------------------------------------------
// dmxr_ctrl
// Frame state: bank renaming, write position, hand-off, publish, counters,
// and the bank clearing sweep after reset.
// ----------------------------------------------------------------------------
module dmxr_ctrl
    import dmxr_pkg::*;
#(
    parameter int MAX_SLOTS = DMXR_MAX_SLOTS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  req_t     item,
    input  logic     notify_enable,
    output logic     busy,
    output mem_cmd_t mem_cmd,
    output stat_t    stat_next
);

    localparam int BANK_SIZE = MAX_SLOTS + 1;
    localparam int POS_W     = $clog2(MAX_SLOTS + 2);
    localparam int ADDR_W    = $clog2(BANK_SIZE);

    logic [1:0]            write_bank_reg, write_bank_next;
    logic [1:0]            readout_bank_reg, readout_bank_next;
    logic [1:0]            pending_bank_reg, pending_bank_next;
    logic [POS_W-1:0]      wpos_reg, wpos_next;
    logic                  rx_en_reg, rx_en_next;
    logic                  consumed_reg, consumed_next;
    logic                  first_reg, first_next;
    logic [DMXR_LEN_W-1:0] len_reg [DMXR_NUM_BANKS];
    logic [DMXR_LEN_W-1:0] len_next [DMXR_NUM_BANKS];
    logic [31:0]           frames_reg, frames_next;
    logic [31:0]           overruns_reg, overruns_next;
    logic [31:0]           ferr_reg, ferr_next;
    logic                  clr_busy_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;

    logic [1:0]            wb;
    logic [1:0]            rb;
    logic [POS_W-1:0]      frame_len;
    logic                  avail;
    logic                  rx_store;

    assign busy = clr_busy_reg;
    assign wb   = bank_ok(write_bank_reg);
    assign rb   = bank_ok(readout_bank_reg);
    assign frame_len = (wpos_reg != '0) ? wpos_reg - POS_W'(1) : '0;

    always_comb
    begin
        write_bank_next   = write_bank_reg;
        readout_bank_next = readout_bank_reg;
        pending_bank_next = pending_bank_reg;
        wpos_next         = wpos_reg;
        rx_en_next        = rx_en_reg;
        consumed_next     = consumed_reg;
        first_next        = first_reg;
        len_next          = len_reg;
        frames_next       = frames_reg;
        overruns_next     = overruns_reg;
        ferr_next         = ferr_reg;
        avail             = 1'b0;
        rx_store          = 1'b0;

        case (item.op)
            OP_RX_BYTE:
            begin
                if (item.framing_error)
                begin
                    ferr_next = ferr_reg + 32'd1;
                end
                if (rx_en_reg)
                begin
                    if (wpos_reg < POS_W'(BANK_SIZE))
                    begin
                        rx_store  = 1'b1;
                        wpos_next = wpos_reg + POS_W'(1);
                    end
                    else
                    begin
                        overruns_next = overruns_reg + 32'd1;
                        rx_en_next    = 1'b0;
                    end
                end
            end
            OP_BREAK:
            begin
                len_next[wb] = DMXR_LEN_W'(frame_len);
                if (frame_len != '0 && pending_bank_reg == NO_BANK && consumed_reg)
                begin
                    pending_bank_next = wb;
                    // the bank that is neither being handed off nor read out
                    write_bank_next   = bank_ok(2'd3 - wb - rb);
                    frames_next       = frames_reg + 32'd1;
                end
                wpos_next  = '0;
                rx_en_next = 1'b1;
            end
            OP_TICK:
            begin
                if (pending_bank_reg != NO_BANK && consumed_reg)
                begin
                    if (first_reg)
                    begin
                        first_next    = 1'b0;
                        consumed_next = 1'b1;
                    end
                    else
                    begin
                        readout_bank_next = bank_ok(pending_bank_reg);
                        consumed_next     = 1'b0;
                        avail             = notify_enable;
                    end
                    pending_bank_next = NO_BANK;
                end
            end
            OP_ACK:
            begin
                consumed_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        mem_cmd = '0;
        if (clr_busy_reg)
        begin
            mem_cmd.wr_en   = '1;
            mem_cmd.wr_addr = DMXR_SLOT_W'(clr_addr_reg);
            mem_cmd.wr_data = 8'h00;
        end
        else
        begin
            mem_cmd.wr_en[wb] = fire && rx_store;
            mem_cmd.wr_addr   = DMXR_SLOT_W'(wpos_reg);
            mem_cmd.wr_data   = item.data;
        end
        mem_cmd.rd_en   = fire;
        mem_cmd.rd_addr = item.slot_index;
    end

    always_comb
    begin
        stat_next.read_hit        = (item.op == OP_READ) &&
                                    (item.slot_index < DMXR_SLOT_W'(BANK_SIZE));
        stat_next.read_bank       = rb;
        stat_next.slot_count      = len_next[bank_ok(readout_bank_next)];
        stat_next.frame_available = avail;
        stat_next.frame_seq       = frames_next;
        stat_next.overrun_count   = overruns_next;
        stat_next.framing_count   = ferr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_bank_reg   <= 2'd0;
            readout_bank_reg <= 2'd2;
            pending_bank_reg <= NO_BANK;
            wpos_reg         <= '0;
            rx_en_reg        <= 1'b1;
            consumed_reg     <= 1'b1;
            first_reg        <= 1'b1;
            for (int i = 0; i < DMXR_NUM_BANKS; i++)
            begin
                len_reg[i] <= '0;
            end
            frames_reg       <= '0;
            overruns_reg     <= '0;
            ferr_reg         <= '0;
        end
        else if (fire)
        begin
            write_bank_reg   <= write_bank_next;
            readout_bank_reg <= readout_bank_next;
            pending_bank_reg <= pending_bank_next;
            wpos_reg         <= wpos_next;
            rx_en_reg        <= rx_en_next;
            consumed_reg     <= consumed_next;
            first_reg        <= first_next;
            len_reg          <= len_next;
            frames_reg       <= frames_next;
            overruns_reg     <= overruns_next;
            ferr_reg         <= ferr_next;
        end
    end

    // zero all banks once after reset, one row of every bank per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(BANK_SIZE - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    a_wr_ne_rd: assert property (@(posedge clk) disable iff (!rst_n)
        write_bank_reg != readout_bank_reg)
        else $error("write bank aliases the read-out bank");

    a_pend_free: assert property (@(posedge clk) disable iff (!rst_n)
        pending_bank_reg != NO_BANK |->
            pending_bank_reg != write_bank_reg && pending_bank_reg != readout_bank_reg)
        else $error("pending bank aliases another bank");

    a_wpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        wpos_reg <= POS_W'(BANK_SIZE))
        else $error("write position beyond bank");

    a_no_fire_clr: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !fire)
        else $error("event processed during bank clearing");

    a_overrun_stop: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.op == OP_RX_BYTE && rx_en_reg && wpos_reg == POS_W'(BANK_SIZE)
            |=> !rx_en_reg)
        else $error("reception not stopped after overrun");

endmodule

// File: bench/tb_dmx512_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// tb_dmx512_frame_receiver_unit
// Self-checking bench for the DMX512 frame receiver: a directed table of
// events, then random frame sequences under varied idling. Each result
// transfer is compared with its table entry or a cycle-free model of the bank renaming.
// ----------------------------------------------------------------------------
module tb_dmx512_frame_receiver_unit;
    import dmxr_pkg::*;

    localparam int          BANK_BYTES   = DMXR_MAX_SLOTS + 1;
    localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
    localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
    localparam int          LONG_HOLD    = 300;

    typedef struct {
        logic [2:0] op;
        logic [7:0] data;
        bit         ferr;
        logic [9:0] slot;
        int         reps;
        bit         typed;
        rsp_t       want;
    } stim_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // model state
    logic [7:0]  bank_mem [0:2][0:BANK_BYTES-1];
    logic [9:0]  bank_len [0:2];
    logic [1:0]  wr_bank, ro_bank, pend_bank;
    int          wr_pos;
    bit          rx_on, consumed, first_frame, notify_en;
    logic [31:0] frame_cnt, ovr_cnt, ferr_cnt;

    rsp_t        status_due [$];
    stim_row_t   dir_plan [$];
    int          errors        = 0;
    int          items_sent    = 0;
    int          published     = 0;
    int          req_idle_pct  = 0;
    int          rsp_stall_pct = 0;
    int          hold_ticket   = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;

    dmx512_frame_receiver_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    initial
    begin
        #(12 * 400000);
        $display("dmx512_frame_receiver_unit: mismatch");
        $finish;
    end

    function automatic int bank_sel(input int b);
        return (b >= 0 && b < 3) ? b : 0;
    endfunction

    task automatic model_reset();
        for (int b = 0; b < 3; b++)
        begin
            bank_len[b] = '0;
            for (int s = 0; s < BANK_BYTES; s++)
                bank_mem[b][s] = '0;
        end
        wr_bank     = 2'd0;
        ro_bank     = 2'd2;
        pend_bank   = NO_BANK;
        wr_pos      = 0;
        rx_on       = 1'b1;
        consumed    = 1'b1;
        first_frame = 1'b1;
        notify_en   = 1'b1;
        frame_cnt   = '0;
        ovr_cnt     = '0;
        ferr_cnt    = '0;
    endtask

    task automatic dmx_rx_predict(input req_t r, output rsp_t o);
        int len;
        int wb;
        o = '0;
        case (r.op)
            OP_RX_BYTE:
            begin
                if (r.framing_error)
                    ferr_cnt++;
                if (rx_on)
                begin
                    if (wr_pos < BANK_BYTES)
                    begin
                        bank_mem[bank_sel(wr_bank)][wr_pos] = r.data;
                        wr_pos++;
                    end
                    else
                    begin
                        ovr_cnt++;
                        rx_on = 1'b0;
                    end
                end
            end
            OP_BREAK:
            begin
                len = (wr_pos > 0) ? wr_pos - 1 : 0;
                wb  = bank_sel(wr_bank);
                bank_len[wb] = len[9:0];
                if (len > 0 && pend_bank == NO_BANK && consumed)
                begin
                    pend_bank = wb[1:0];
                    wr_bank   = 2'(bank_sel(3 - wb - bank_sel(ro_bank)));
                    frame_cnt++;
                end
                wr_pos = 0;
                rx_on  = 1'b1;
            end
            OP_TICK:
            begin
                if (pend_bank != NO_BANK && consumed)
                begin
                    if (first_frame)
                        first_frame = 1'b0;   // very first frame is thrown away
                    else
                    begin
                        ro_bank  = 2'(bank_sel(pend_bank));
                        consumed = 1'b0;
                        o.frame_available = notify_en;
                        published++;
                    end
                    pend_bank = NO_BANK;
                end
            end
            OP_ACK:
                consumed = 1'b1;
            OP_READ:
            begin
                if (r.slot_index < BANK_BYTES)
                    o.read_data = bank_mem[bank_sel(ro_bank)][r.slot_index];
            end
            default: ;
        endcase
        o.slot_count    = bank_len[bank_sel(ro_bank)];
        o.frame_seq     = frame_cnt;
        o.overrun_count = ovr_cnt;
        o.framing_count = ferr_cnt;
    endtask

    task automatic report(input string fld, input logic [31:0] want, input logic [31:0] got);
        $display("%0t %s: expected %0h, got %0h", $time, fld, want, got);
        errors++;
    endtask

    // result side: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_ticket != hold_seen)
        begin
            rsp_ready <= 1'b0;
            hold_seen <= hold_ticket;
            hold_left <= LONG_HOLD;
        end
        else
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        rsp_t w;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (status_due.size() == 0)
            begin
                $display("%0t unexpected transfer: expected none, got %h", $time, rsp);
                errors++;
            end
            else
            begin
                w = status_due.pop_front();
                if (rsp.read_data !== w.read_data)
                    report("read_data", 32'(w.read_data), 32'(rsp.read_data));
                if (rsp.slot_count !== w.slot_count)
                    report("slot_count", 32'(w.slot_count), 32'(rsp.slot_count));
                if (rsp.frame_available !== w.frame_available)
                    report("frame_available", 32'(w.frame_available), 32'(rsp.frame_available));
                if (rsp.frame_seq !== w.frame_seq)
                    report("frame_seq", w.frame_seq, rsp.frame_seq);
                if (rsp.overrun_count !== w.overrun_count)
                    report("overrun_count", w.overrun_count, rsp.overrun_count);
                if (rsp.framing_count !== w.framing_count)
                    report("framing_count", w.framing_count, rsp.framing_count);
            end
        end
    end

    task automatic send_item(input req_t r, input bit typed, input rsp_t want);
        rsp_t p;
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        dmx_rx_predict(r, p);
        status_due.push_back(typed ? want : p);
        items_sent++;
    endtask

    task automatic send_op(input logic [2:0] op, input logic [7:0] data, input bit ferr,
                           input logic [9:0] slot);
        req_t r;
        r.op            = op;
        r.data          = data;
        r.framing_error = ferr;
        r.slot_index    = slot;
        send_item(r, 1'b0, '0);
    endtask

    task automatic set_notify(input bit v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        notify_en = v;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic add_row(input logic [2:0] op, input logic [7:0] data, input bit ferr,
                           input logic [9:0] slot, input int reps, input bit typed,
                           input rsp_t want);
        stim_row_t row;
        row.op    = op;
        row.data  = data;
        row.ferr  = ferr;
        row.slot  = slot;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        dir_plan.push_back(row);
    endtask

    task automatic run_random(input int n);
        int done;
        int start;
        int kind;
        int n_slots;
        done = 0;
        while (done < n)
        begin
            start   = items_sent;
            kind    = $urandom_range(99);
            if (kind < 50)
            begin
                // well-formed frame: start code, slots, break, often a publish tick, then read back
                if ($urandom_range(1))
                    send_op(OP_ACK, 8'($urandom), 1'($urandom), 10'($urandom));
                n_slots = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
                send_op(OP_RX_BYTE, 8'($urandom), $urandom_range(9) == 0, 10'($urandom));
                for (int k = 0; k < n_slots; k++)
                    send_op(OP_RX_BYTE, 8'($urandom), $urandom_range(9) == 0,
                            10'($urandom));
                send_op(OP_BREAK, 8'($urandom), 1'($urandom), 10'($urandom));
                if ($urandom_range(9) < 7)
                    send_op(OP_TICK, 8'($urandom), 1'($urandom), 10'($urandom));
                repeat ($urandom_range(1, 4))
                    send_op(OP_READ, 8'($urandom), 1'($urandom),
                            ($urandom_range(9) == 0) ? 10'($urandom_range(1023))
                                                     : 10'($urandom_range(15)));
            end
            else if (kind < 62)
                send_op(OP_ACK, 8'($urandom), 1'($urandom), 10'($urandom));
            else if (kind < 72)
                send_op(OP_TICK, 8'($urandom), 1'($urandom), 10'($urandom));
            else if (kind < 82)
                send_op(OP_READ, 8'($urandom), 1'($urandom), 10'($urandom));
            else if (kind < 88)
                send_op(OP_BREAK, 8'($urandom), 1'($urandom), 10'($urandom));
            else if (kind < 95)
                send_op(OP_RX_BYTE, 8'($urandom), 1'($urandom), 10'($urandom));
            else
                send_op(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 8'($urandom),
                        1'($urandom), 10'($urandom));
            done += items_sent - start;
        end
    endtask

    initial
    begin
        rsp_t      zero;
        rsp_t      ferr_one;
        stim_row_t row;
        req_t      r;

        zero     = '0;
        ferr_one = '0;
        ferr_one.framing_count = 32'd1;
        model_reset();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_notify(1'b1);

        add_row(OP_READ,      8'h00, 1'b0, 10'd0,   1,   1'b1, zero);
        add_row(OP_READ,      8'hFF, 1'b1, 10'd512, 1,   1'b1, zero);
        add_row(OP_READ,      8'h00, 1'b0, 10'h3FF, 1,   1'b1, zero);
        add_row(OP_UNUSED_LO, 8'hFF, 1'b1, 10'h3FF, 1,   1'b1, zero);
        add_row(OP_UNUSED_HI, 8'hFF, 1'b1, 10'h3FF, 1,   1'b1, zero);
        add_row(OP_ACK,       8'h00, 1'b0, 10'd0,   1,   1'b1, zero);
        add_row(OP_BREAK,     8'h00, 1'b0, 10'd0,   1,   1'b1, zero);  // empty frame
        add_row(OP_RX_BYTE,   8'h00, 1'b0, 10'd0,   1,   1'b1, zero);
        add_row(OP_BREAK,     8'h00, 1'b0, 10'd0,   1,   1'b1, zero);  // start code only
        add_row(OP_RX_BYTE,   8'hFF, 1'b1, 10'd0,   1,   1'b1, ferr_one);
        add_row(OP_RX_BYTE,   8'hA5, 1'b0, 10'd0,   1,   1'b0, zero);
        add_row(OP_RX_BYTE,   8'h5A, 1'b0, 10'd0,   1,   1'b0, zero);
        add_row(OP_BREAK,     8'h00, 1'b0, 10'd0,   1,   1'b0, zero);
        add_row(OP_TICK,      8'h00, 1'b0, 10'd0,   1,   1'b0, zero);  // first frame dropped
        add_row(OP_RX_BYTE,   8'h00, 1'b0, 10'd0,   1,   1'b0, zero);
        add_row(OP_RX_BYTE,   8'h01, 1'b0, 10'd0,   512, 1'b0, zero);  // full frame
        add_row(OP_RX_BYTE,   8'hF0, 1'b1, 10'd0,   3,   1'b0, zero);  // overrun, then dropped
        add_row(OP_BREAK,     8'h00, 1'b0, 10'd0,   1,   1'b0, zero);
        add_row(OP_TICK,      8'h00, 1'b0, 10'd0,   1,   1'b0, zero);
        add_row(OP_READ,      8'h00, 1'b0, 10'd0,   1,   1'b0, zero);
        add_row(OP_READ,      8'h00, 1'b0, 10'd512, 1,   1'b0, zero);
        add_row(OP_READ,      8'h00, 1'b0, 10'd513, 1,   1'b0, zero);
        add_row(OP_BREAK,     8'h00, 1'b0, 10'd0,   1,   1'b0, zero);
        add_row(OP_TICK,      8'h00, 1'b0, 10'd0,   1,   1'b0, zero);  // nothing pending
        add_row(OP_ACK,       8'h00, 1'b0, 10'd0,   1,   1'b0, zero);

        foreach (dir_plan[j])
        begin
            row = dir_plan[j];
            for (int i = 0; i < row.reps; i++)
            begin
                r.op            = row.op;
                r.data          = row.data + i[7:0];
                r.framing_error = row.ferr;
                r.slot_index    = row.slot;
                send_item(r, row.typed, row.want);
            end
        end
        drain();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin req_idle_pct = 53; rsp_stall_pct = 0;  end
                2: begin req_idle_pct = 0;  rsp_stall_pct = 53; end
                default: begin req_idle_pct = 9; rsp_stall_pct = 9; end
            endcase
            set_notify(p[0]);
            if (p == 0)
                hold_ticket <= hold_ticket + 1;   // result side backs off while input floods
            run_random(30);
            drain();
        end

        $display("%0d events, %0d frames handed off, %0d published, %0d overruns, %0d framing errors",
                 items_sent, frame_cnt, published, ovr_cnt, ferr_cnt);
        $display("notify on and off; no idling, sender gaps, result stalls, both; one long stall");
        if (errors == 0)
            $display("dmx512_frame_receiver_unit: match");
        else
            $display("dmx512_frame_receiver_unit: mismatch");
        $finish;
    end

endmodule
